@@ rtl/crcmd_pkg.sv @@
// Shared constants and types of the bit-serial CRC divider.
`default_nettype none

package crcmd_pkg;

	localparam int TAPS_W     = 32;
	localparam int DEG_W      = 6;
	localparam int STATE_W    = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b1;

	localparam logic [TAPS_W-1:0] TAPS_RST = 32'd3;
	localparam logic [DEG_W-1:0]  DEG_RST  = 6'd3;

	typedef struct packed {
		logic out_bit;
		logic is_remainder;
		logic last_of_run;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/crcmd_front.sv @@
// Front end: configuration registers, remainder update and job classification.
`default_nettype none

module crcmd_front import crcmd_pkg::*; #(
	parameter int W  = 32,
	parameter int DW = 6,
	parameter int IW = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	input  wire logic                  q_full,
	input  wire logic                  data_bit,
	input  wire logic                  end_of_message,
	output logic                       job_push,
	output logic                       job_fb,
	output logic                       job_eom,
	output logic [DW-1:0]              job_deg,
	output logic [W-1:0]               job_rem
);

	logic [TAPS_W-1:0] taps_q;
	logic [DEG_W-1:0]  deg_q;
	logic [W-1:0]      part_q;

	logic [W-1:0]      taps_w;
	logic [DEG_W:0]    deg_ext;
	logic [DEG_W:0]    deg_clamp;
	logic [DW-1:0]     d;
	logic [DW-1:0]     dm1;
	logic [W-1:0]      mask;
	logic [W-1:0]      keep;
	logic [W-1:0]      rem_cur;
	logic [W-1:0]      rem_nxt;
	logic              fb;

	generate
		if (W > TAPS_W) begin : g_taps_wide
			assign taps_w = {{(W-TAPS_W){1'b0}}, taps_q};
		end else begin : g_taps_narrow
			assign taps_w = taps_q[W-1:0];
		end
	endgenerate

	always_comb begin
		deg_ext = {1'b0, deg_q};
		if (deg_q == '0) begin
			deg_clamp = (DEG_W+1)'(1);
		end else if (deg_ext > (DEG_W+1)'(W)) begin
			deg_clamp = (DEG_W+1)'(W);
		end else begin
			deg_clamp = deg_ext;
		end
		d   = DW'(deg_clamp);
		dm1 = d - DW'(1);
		for (int i = 0; i < W; i++) begin
			mask[i] = (i < int'(d));
			keep[i] = (i < STATE_W);
		end
		rem_cur = part_q & mask;
		fb      = data_bit ^ rem_cur[dm1[IW-1:0]];
		rem_nxt = ((rem_cur << 1) & mask) ^ ({W{fb}} & taps_w & mask);
	end

	assign job_push = push && !q_full;
	assign job_fb   = fb;
	assign job_eom  = end_of_message;
	assign job_deg  = d;
	assign job_rem  = rem_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= TAPS_RST;
			deg_q  <= DEG_RST;
			part_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TAPS:   taps_q <= cfg_data[TAPS_W-1:0];
					CFG_DEGREE: deg_q  <= cfg_data[DEG_W-1:0];
					default:    ;
				endcase
			end
			if (job_push) begin
				part_q <= end_of_message ? '0 : (rem_nxt & keep);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/crcmd_queue.sv @@
// Short job queue between the front and back ends.
`default_nettype none

module crcmd_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	output logic [DATA_W-1:0]      rd_data,
	output logic                   full,
	output logic                   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/crcmd_back.sv @@
// Back end: emits quotient and remainder bits into the result register.
`default_nettype none

module crcmd_back import crcmd_pkg::*; #(
	parameter int W  = 32,
	parameter int DW = 6,
	parameter int IW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire logic          job_fb,
	input  wire logic          job_eom,
	input  wire logic [DW-1:0] job_deg,
	input  wire logic [W-1:0]  job_rem,
	output logic               job_done,
	input  wire logic          res_pop,
	output result_t            res,
	output logic               res_valid
);

	result_t       res_q;
	logic          res_v_q;
	logic [DW-1:0] cnt_q;

	result_t       nxt;
	logic [DW-1:0] cnt_m1;
	logic          adv;
	logic          fin;

	always_comb begin
		adv    = job_valid && (!res_v_q || res_pop);
		cnt_m1 = cnt_q - DW'(1);
		if (cnt_q == '0) begin
			nxt.out_bit      = job_fb;
			nxt.is_remainder = 1'b0;
			nxt.last_of_run  = !job_eom;
			fin              = !job_eom;
		end else begin
			nxt.out_bit      = job_rem[cnt_m1[IW-1:0]];
			nxt.is_remainder = 1'b1;
			nxt.last_of_run  = (cnt_q == DW'(1));
			fin              = (cnt_q == DW'(1));
		end
	end

	assign job_done  = adv && fin;
	assign res       = res_q;
	assign res_valid = res_v_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (adv) begin
				res_v_q <= 1'b1;
				if (cnt_q == '0) begin
					cnt_q <= job_eom ? job_deg : '0;
				end else begin
					cnt_q <= cnt_m1;
				end
			end else if (res_pop) begin
				res_v_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/crc_modulo2_divider_top.sv @@
// Top level of the bit-serial CRC divider with configurable polynomial.
//
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------
//  config    | cfg_we           | cfg_index, cfg_data
//  input     | push / full      | data_bit, end_of_message
//  result    | empty / pop      | out_bit, is_remainder, last_of_run
//
//  One message bit is taken per cycle while the queue is not full; an ordinary bit yields
//  one result a cycle while results are popped. A final bit yields its quotient bit, then
//  degree check bits; the front keeps taking bits until the two-entry job queue fills.
//  Jobs pass the queue and then the result register; a withheld pop stalls the back end and, via full, the front.
//  Reset clears the remainder and loads taps 3, degree 3; no clearing pass is needed.
`default_nettype none

module crc_modulo2_divider_top import crcmd_pkg::*; #(
	parameter int MAX_DEGREE = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  data_bit,
	input  wire logic                  end_of_message,
	output logic                       empty,
	input  wire logic                  pop,
	output logic                       out_bit,
	output logic                       is_remainder,
	output logic                       last_of_run
);

	localparam int W      = MAX_DEGREE;
	localparam int DW     = $clog2(W + 1);
	localparam int IW     = (W > 1) ? $clog2(W) : 1;
	localparam int JOB_W  = W + DW + 2;
	localparam int QDEPTH = 2;

	logic              job_push;
	logic              job_fb;
	logic              job_eom;
	logic [DW-1:0]     job_deg;
	logic [W-1:0]      job_rem;
	logic [JOB_W-1:0]  q_wdata;
	logic [JOB_W-1:0]  q_rdata;
	logic              q_full;
	logic              q_empty;
	logic              job_done;
	result_t           res;
	logic              res_valid;

	crcmd_front #(
		.W  (W),
		.DW (DW),
		.IW (IW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.q_full         (q_full),
		.data_bit       (data_bit),
		.end_of_message (end_of_message),
		.job_push       (job_push),
		.job_fb         (job_fb),
		.job_eom        (job_eom),
		.job_deg        (job_deg),
		.job_rem        (job_rem)
	);

	assign q_wdata = {job_fb, job_eom, job_deg, job_rem};

	crcmd_queue #(
		.DATA_W (JOB_W),
		.DEPTH  (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (q_wdata),
		.rd_en   (job_done),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	crcmd_back #(
		.W  (W),
		.DW (DW),
		.IW (IW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job_fb    (q_rdata[JOB_W-1]),
		.job_eom   (q_rdata[JOB_W-2]),
		.job_deg   (q_rdata[W+DW-1:W]),
		.job_rem   (q_rdata[W-1:0]),
		.job_done  (job_done),
		.res_pop   (pop),
		.res       (res),
		.res_valid (res_valid)
	);

	assign full         = q_full;
	assign empty        = !res_valid;
	assign out_bit      = res.out_bit;
	assign is_remainder = res.is_remainder;
	assign last_of_run  = res.last_of_run;

`ifndef SYNTHESIS
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("job queue reports full and empty together");

	a_request_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> (!q_empty || !empty))
		else $error("accepted request vanished");

	a_check_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !is_remainder && !last_of_run) |=> (!empty && is_remainder))
		else $error("final quotient bit not followed by a check bit");
`endif

endmodule

`default_nettype wire

@@ verif/tb_crc_modulo2_divider_top.sv @@
// Testbench for the bit-serial CRC divider: random messages, a shadow divider, in-order check.
module tb_crc_modulo2_divider_top;
	import crcmd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DEG    = 32;
	localparam int PHASE_BITS = 48;

	typedef struct {
		logic data;
		logic eom;
	} msg_bit_t;

	typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_BLOCKS} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAPS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic                  data_bit = 1'b0;
	logic                  end_of_message = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  out_bit;
	logic                  is_remainder;
	logic                  last_of_run;

	logic [TAPS_W-1:0]  poly_taps = TAPS_RST;
	logic [DEG_W-1:0]   poly_degree = DEG_RST;
	logic [STATE_W-1:0] crc_rem = '0;

	msg_bit_t msg_bits_q[$];
	result_t  crc_out_q[$];

	int       fault_cnt = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       rx_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	logic     rx_hold = 1'b0;
	logic     hold_arm = 1'b0;

	crc_modulo2_divider_top #(
		.MAX_DEGREE(MAX_DEG)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.data_bit(data_bit),
		.end_of_message(end_of_message),
		.empty(empty),
		.pop(pop),
		.out_bit(out_bit),
		.is_remainder(is_remainder),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void divide_step(input logic din, input logic eom);
		int unsigned        d;
		logic [STATE_W-1:0] mask;
		logic [STATE_W-1:0] r;
		logic               fb;
		result_t            res;
		d = poly_degree;
		if (d < 1) d = 1;
		if (d > MAX_DEG) d = MAX_DEG;
		mask = STATE_W'((64'd1 << d) - 64'd1);
		r = crc_rem & mask;
		fb = din ^ r[d-1];
		r = (r << 1) & mask;
		if (fb) r = r ^ (poly_taps & mask);
		res.out_bit = fb;
		res.is_remainder = 1'b0;
		res.last_of_run = !eom;
		crc_out_q.push_back(res);
		if (!eom) begin
			crc_rem = r;
		end else begin
			for (int i = d; i > 0; i--) begin
				res.out_bit = r[i-1];
				res.is_remainder = 1'b1;
				res.last_of_run = (i == 1);
				crc_out_q.push_back(res);
			end
			crc_rem = '0;
		end
	endfunction

	always @(posedge clk) begin
		msg_bit_t nxt;
		if (push && !full) divide_step(data_bit, end_of_message);
		if (!push || !full) begin
			if (gap_left != 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (msg_bits_q.size() != 0) begin
				nxt = msg_bits_q.pop_front();
				push <= 1'b1;
				data_bit <= nxt.data;
				end_of_message <= nxt.eom;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (pop && !empty) begin
			got.out_bit = out_bit;
			got.is_remainder = is_remainder;
			got.last_of_run = last_of_run;
			if (crc_out_q.size() == 0) begin
				if (fault_cnt < 10)
					$display("%0t: result with nothing expected: bit %b rem %b last %b",
						$realtime, got.out_bit, got.is_remainder, got.last_of_run);
				fault_cnt++;
			end else begin
				want = crc_out_q.pop_front();
				if (got.out_bit !== want.out_bit || got.is_remainder !== want.is_remainder ||
						got.last_of_run !== want.last_of_run) begin
					if (fault_cnt < 10)
						$display("%0t: mismatch: exp bit %b rem %b last %b, got bit %b rem %b last %b",
							$realtime, want.out_bit, want.is_remainder, want.last_of_run,
							got.out_bit, got.is_remainder, got.last_of_run);
					fault_cnt++;
				end
			end
		end
		if (rx_left != 0) begin
			rx_left--;
		end else begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 64);
		end
		case (rx_mode)
			RX_FREE:   pop <= !rx_hold;
			RX_HALF:   pop <= !rx_hold && ($urandom_range(0, 1) == 1);
			RX_SPARSE: pop <= !rx_hold && ($urandom_range(0, 3) == 0);
			default:   pop <= !rx_hold && (rx_left[2] == 1'b1);
		endcase
	end

	initial begin
		wait (hold_arm);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("crc_modulo2_divider_top verification failed");
		$finish;
	end

	task automatic add_bit(input logic d, input logic e);
		msg_bit_t b;
		b.data = d;
		b.eom = e;
		msg_bits_q.push_back(b);
	endtask

	task automatic settle();
		while (msg_bits_q.size() != 0 || push || crc_out_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TAPS) poly_taps = val;
		else poly_degree = val[DEG_W-1:0];
	endtask

	task automatic set_poly(input logic [TAPS_W-1:0] taps, input logic [DEG_W-1:0] deg);
		write_reg(CFG_TAPS, taps);
		write_reg(CFG_DEGREE, ($urandom & ~32'h3F) | CFG_DATA_W'(deg));
	endtask

	initial begin
		int   n;
		int   len;
		logic open;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b1);
		add_bit(1'b1, 1'b1);
		settle();
		set_poly(32'hFFFF_FFFF, 6'd0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b1);
		settle();
		set_poly(32'hFFFF_FFFF, 6'd63);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b1);
		settle();
		set_poly(32'hFFFF_FFFF, 6'd4);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b1);
		settle();
		set_poly(32'h0000_0000, 6'd1);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b1);
		settle();
		set_poly(32'h04C1_1DB7, 6'd32);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b0);
		settle();
		write_reg(CFG_DEGREE, 32'd5);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b1);

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			case (ph)
				0:       set_poly(32'h04C1_1DB7, 6'd32);
				1:       set_poly(32'h0000_1021, 6'd16);
				2:       set_poly(32'h0000_0007, 6'd8);
				3:       set_poly(32'h0000_0000, 6'd63);
				4:       set_poly(32'hFFFF_FFFF, 6'd0);
				5:       set_poly($urandom, 6'd8);
				default: set_poly($urandom, 6'($urandom_range(0, 63)));
			endcase
			if (ph == 5) hold_arm = 1'b1;
			n = 0;
			while (n < PHASE_BITS) begin
				len = $urandom_range(1, 24);
				if (n + len > PHASE_BITS) len = PHASE_BITS - n;
				open = (n + len == PHASE_BITS) && ($urandom_range(0, 3) == 0);
				for (int k = 0; k < len; k++)
					add_bit(1'($urandom_range(0, 1)), !open && (k == len - 1));
				n += len;
			end
		end

		settle();
		repeat (20) @(negedge clk);
		if (crc_out_q.size() != 0) fault_cnt++;
		if (fault_cnt == 0) begin
			$display("crc_modulo2_divider_top verification clean");
		end else begin
			$display("crc_modulo2_divider_top verification failed");
		end
		$finish;
	end

endmodule
